/* hw/rtl/stmmt_pkg.sv */
// stmmt_pkg: shared types and constants for the sparse table min/max tracker
// no dependencies; imported by the core, its checker and the testbench
package stmmt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int SCAN_CHUNK      = 16;
    localparam int COUNT_W         = 9;
    localparam logic [31:0] BASE_RESET = 32'd8;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_GET    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] index;
        logic [31:0]        entry_value;
    } t_cmd;

    typedef struct packed {
        logic [31:0]         entry_out;
        logic                found;
        logic                out_of_window;
        logic [COUNT_W-1:0]  occupied_count;
        logic signed [31:0]  lowest_index;
        logic signed [31:0]  highest_index;
    } t_result;

endpackage

/* hw/rtl/sparse_table_min_max_tracker_core.sv */
// sparse table min/max tracker core: slot memory, valid bits, count and bounds
// depends on stmmt_pkg
// add, get, out of window, unused code or remove of an empty slot: strobe is registered from S_EXEC
// remove of an occupied slot: strobe is registered from S_FIN, after the S_SCAN states of the bound
// rescan walking the valid bits 16 slots per cycle
// a new transaction is accepted in the strobe cycle; the receiver cannot stall
// reset is synchronous, active low: valid bits, count and bounds clear, base returns to 8
module sparse_table_min_max_tracker_core #(
    parameter int TABLE_DEPTH = stmmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  stmmt_pkg::t_cmd   i_cmd,
    output logic              strobe,
    output stmmt_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);
    import stmmt_pkg::*;

    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int CW         = (TABLE_DEPTH < SCAN_CHUNK) ? TABLE_DEPTH : SCAN_CHUNK;
    localparam int NUM_CHUNKS = (TABLE_DEPTH + CW - 1) / CW;
    localparam int PAD_W      = NUM_CHUNKS * CW;
    localparam int CH_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BIT_W      = $clog2(CW);
    localparam int POS_W      = $clog2(PAD_W);
    localparam int CNT_EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [31:0]            r_base;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    logic [31:0]            r_min;
    logic [31:0]            r_max;
    logic                   r_strobe;

    logic [31:0]            r_mem [TABLE_DEPTH];
    logic [31:0]            r_rdata;

    logic [1:0]             r_func;
    logic [31:0]            r_index;
    logic [31:0]            r_value;
    logic                   r_inwin;
    logic [ADDR_W-1:0]      r_addr;
    logic [31:0]            r_entry;
    logic                   r_found;
    logic                   r_oow;
    logic [CH_W-1:0]        r_chunk;
    logic                   r_seen;
    logic [POS_W-1:0]       r_min_pos;
    logic [POS_W-1:0]       r_max_pos;

    logic [32:0]            in_off;
    logic                   in_inwin;
    logic [ADDR_W-1:0]      in_addr;
    logic                   accept;
    logic                   op_valid;
    logic                   old_found;
    logic                   do_add;
    logic                   do_rm;
    logic                   mem_we;
    logic                   scan_last;
    logic [PAD_W-1:0]       valid_pad;
    logic [CW-1:0]          vgroups [NUM_CHUNKS];
    logic [CW-1:0]          grp;
    logic [BIT_W-1:0]       lo_bit;
    logic [BIT_W-1:0]       hi_bit;
    logic [POS_W-1:0]       scan_base;
    logic [POS_W-1:0]       lo_pos;
    logic [POS_W-1:0]       hi_pos;
    logic [CNT_EXT_W-1:0]   cnt_ext;

    // window offset of the incoming index
    assign in_off   = {i_cmd.index[31], i_cmd.index} - {r_base[31], r_base};
    assign in_inwin = !in_off[32] && (in_off < 33'(TABLE_DEPTH));
    assign in_addr  = in_off[ADDR_W-1:0];
    assign accept   = start && (r_state == S_IDLE);

    assign op_valid  = r_inwin && (r_func != FUNC_NOP);
    assign old_found = op_valid && r_valid[r_addr];
    assign do_add    = op_valid && (r_func == FUNC_ADD) && (r_value != 32'd0);
    assign do_rm     = op_valid && (r_func == FUNC_REMOVE) && old_found;
    assign mem_we    = (r_state == S_EXEC) && do_add;
    assign scan_last = (r_chunk == CH_W'(NUM_CHUNKS - 1));

    // rescan: one group of valid bits per cycle
    assign valid_pad = PAD_W'(r_valid);

    always_comb begin
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            vgroups[c] = valid_pad[c*CW +: CW];
        end
    end

    assign grp = vgroups[r_chunk];

    always_comb begin
        lo_bit = '0;
        hi_bit = '0;
        for (int i = CW - 1; i >= 0; i--) begin
            if (grp[i]) begin
                lo_bit = BIT_W'(i);
            end
        end
        for (int i = 0; i < CW; i++) begin
            if (grp[i]) begin
                hi_bit = BIT_W'(i);
            end
        end
    end

    assign scan_base = POS_W'(int'(r_chunk) * CW);
    assign lo_pos    = scan_base + POS_W'(lo_bit);
    assign hi_pos    = scan_base + POS_W'(hi_bit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = do_rm ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= r_value;
        end
        if (accept) begin
            r_rdata <= r_mem[in_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_valid  <= '0;
            r_count  <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_base   <= BASE_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= ((r_state == S_EXEC) && !do_rm) || (r_state == S_FIN);
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_state == S_EXEC) begin
                if (do_add) begin
                    r_valid[r_addr] <= 1'b1;
                    if (!old_found) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (r_count == '0) begin
                        r_min <= r_index;
                        r_max <= r_index;
                    end else begin
                        if ($signed(r_index) < $signed(r_min)) begin
                            r_min <= r_index;
                        end
                        if ($signed(r_index) > $signed(r_max)) begin
                            r_max <= r_index;
                        end
                    end
                end
                if (do_rm) begin
                    r_valid[r_addr] <= 1'b0;
                    r_count         <= r_count - CNT_W'(1);
                end
            end
            if (r_state == S_FIN) begin
                if (r_seen) begin
                    r_min <= r_base + 32'(r_min_pos);
                    r_max <= r_base + 32'(r_max_pos);
                end else begin
                    r_min <= '0;
                    r_max <= '0;
                end
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_cmd.func;
            r_index <= i_cmd.index;
            r_value <= i_cmd.entry_value;
            r_inwin <= in_inwin;
            r_addr  <= in_addr;
        end
        if (r_state == S_EXEC) begin
            r_entry   <= (old_found && (r_func != FUNC_ADD)) ? r_rdata : 32'd0;
            r_found   <= old_found;
            r_oow     <= !r_inwin && (r_func != FUNC_NOP);
            r_chunk   <= '0;
            r_seen    <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_chunk <= r_chunk + CH_W'(1);
            if (grp != '0) begin
                if (!r_seen) begin
                    r_min_pos <= lo_pos;
                end
                r_max_pos <= hi_pos;
                r_seen    <= 1'b1;
            end
        end
    end

    assign cnt_ext = CNT_EXT_W'(r_count);

    assign busy   = (r_state != S_IDLE);
    assign strobe = r_strobe;

    assign o_result.entry_out      = r_entry;
    assign o_result.found          = r_found;
    assign o_result.out_of_window  = r_oow;
    assign o_result.occupied_count = cnt_ext[COUNT_W-1:0];
    assign o_result.lowest_index   = r_min;
    assign o_result.highest_index  = r_max;

endmodule

/* hw/rtl/stmmt_checker.sv */
// stmmt_checker: port-level checks on the tracker core, bound into the core module
// depends on stmmt_pkg and sparse_table_min_max_tracker_core
module stmmt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input stmmt_pkg::t_result o_result
);
    import stmmt_pkg::*;

    // accepted transaction keeps the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepted transaction");

    // results appear only while idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> !busy)
        else $error("result strobe while busy");

    // empty table reports zero bounds
    a_empty_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && (o_result.occupied_count == '0)) |->
        ((o_result.lowest_index == '0) && (o_result.highest_index == '0)))
        else $error("nonzero bounds on empty table");

    // out of window is never found
    a_oow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_result.out_of_window) |->
        (!o_result.found && (o_result.entry_out == 32'd0)))
        else $error("out of window transaction reported an entry");

    // entry only returned from an occupied slot
    a_entry_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_result.found) |-> (o_result.entry_out == 32'd0))
        else $error("entry returned from empty slot");

endmodule

bind sparse_table_min_max_tracker_core stmmt_checker u_stmmt_checker (.*);

/* test/testbench.sv */
// testbench for sparse_table_min_max_tracker_core: directed and random transactions
// checked against a behavioral table kept in the testbench; depends on stmmt_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import stmmt_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        strobe;
    t_result     o_result;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    logic [31:0]        slot_mem [DEPTH];
    logic [8:0]         occ_count;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic signed [31:0] base_reg;
    t_result            pending_results [$];
    t_result            want_r;
    int                 fails;
    bit                 no_gaps;

    sparse_table_min_max_tracker_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .strobe      (strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("testbench failed");
        $finish;
    end

    function automatic void find_bounds();
        logic seen;
        logic [31:0] idx;
        seen = 1'b0;
        for (int p = 0; p < DEPTH; p++) begin
            if (slot_mem[p] != 32'd0) begin
                idx = base_reg + p;
                if (!seen) low_bound = idx;
                high_bound = idx;
                seen = 1'b1;
            end
        end
        if (!seen) begin
            low_bound = '0;
            high_bound = '0;
        end
    endfunction

    function automatic t_result track_table(t_cmd c);
        t_result r;
        longint off;
        int p;
        logic [31:0] prev;
        r = '0;
        off = longint'($signed(c.index)) - longint'(base_reg);
        if (c.func != FUNC_NOP) begin
            if (off < 0 || off >= DEPTH) begin
                r.out_of_window = 1'b1;
            end else begin
                p = int'(off);
                prev = slot_mem[p];
                r.found = (prev != 32'd0);
                case (c.func)
                    FUNC_ADD: begin
                        if (c.entry_value != 32'd0) begin
                            if (occ_count == 0) begin
                                low_bound = c.index;
                                high_bound = c.index;
                            end else begin
                                if ($signed(c.index) < low_bound) low_bound = c.index;
                                if ($signed(c.index) > high_bound) high_bound = c.index;
                            end
                            if (prev == 32'd0) occ_count++;
                            slot_mem[p] = c.entry_value;
                        end
                    end
                    FUNC_GET: begin
                        r.entry_out = prev;
                    end
                    FUNC_REMOVE: begin
                        r.entry_out = prev;
                        if (prev != 32'd0) begin
                            slot_mem[p] = 32'd0;
                            if (occ_count != 0) occ_count--;
                            find_bounds();
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        r.occupied_count = occ_count;
        r.lowest_index = low_bound;
        r.highest_index = high_bound;
        return r;
    endfunction

    function automatic t_cmd make_cmd(logic [1:0] f, logic [31:0] idx, logic [31:0] v);
        t_cmd c;
        c.func = f;
        c.index = idx;
        c.entry_value = v;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 32'd0;
        if (r < 16) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_index(int lo_p, int span);
        int r;
        longint t;
        r = $urandom_range(0, 99);
        if (r < 85) t = longint'(base_reg) + lo_p + $urandom_range(0, span - 1);
        else if (r < 89) t = longint'(base_reg) - 1 - $urandom_range(0, 3);
        else if (r < 93) t = longint'(base_reg) + DEPTH + $urandom_range(0, 3);
        else t = $urandom;
        return 32'(t);
    endfunction

    function automatic logic [1:0] pick_func(int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct) return FUNC_ADD;
        if (r < add_pct + (95 - add_pct) / 3) return FUNC_GET;
        if (r < 95) return FUNC_REMOVE;
        return FUNC_NOP;
    endfunction

    task automatic send_item(t_cmd c);
        int gap;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(track_table(c));
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_base(logic [31:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        base_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && strobe) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no transaction pending");
                fails++;
            end else begin
                want_r = pending_results.pop_front();
                check_field("entry_out", want_r.entry_out, o_result.entry_out);
                check_field("found", 32'(want_r.found), 32'(o_result.found));
                check_field("out_of_window", 32'(want_r.out_of_window),
                            32'(o_result.out_of_window));
                check_field("occupied_count", 32'(want_r.occupied_count),
                            32'(o_result.occupied_count));
                check_field("lowest_index", want_r.lowest_index, o_result.lowest_index);
                check_field("highest_index", want_r.highest_index, o_result.highest_index);
            end
        end
    end

    task automatic test_directed();
        send_item(make_cmd(FUNC_GET, 32'd8, 32'd0));
        send_item(make_cmd(FUNC_REMOVE, 32'd8, 32'd0));
        send_item(make_cmd(FUNC_ADD, 32'd8, 32'd0));
        send_item(make_cmd(FUNC_ADD, 32'd100, 32'hFFFF_FFFF));
        send_item(make_cmd(FUNC_ADD, 32'd8, 32'd1));
        send_item(make_cmd(FUNC_ADD, 32'd263, 32'h8000_0000));
        send_item(make_cmd(FUNC_ADD, 32'd100, 32'd5));
        send_item(make_cmd(FUNC_ADD, 32'd100, 32'd0));
        send_item(make_cmd(FUNC_GET, 32'd100, 32'hA5A5_A5A5));
        send_item(make_cmd(FUNC_ADD, 32'd7, 32'd3));
        send_item(make_cmd(FUNC_ADD, 32'd264, 32'd3));
        send_item(make_cmd(FUNC_GET, 32'h8000_0000, 32'd0));
        send_item(make_cmd(FUNC_REMOVE, 32'h7FFF_FFFF, 32'd0));
        send_item(make_cmd(FUNC_NOP, 32'd100, 32'd9));
        send_item(make_cmd(FUNC_REMOVE, 32'd263, 32'd0));
        send_item(make_cmd(FUNC_REMOVE, 32'd8, 32'd0));
        send_item(make_cmd(FUNC_GET, 32'd263, 32'd0));
        send_item(make_cmd(FUNC_REMOVE, 32'd100, 32'd0));
        send_item(make_cmd(FUNC_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_cmd(FUNC_ADD, 32'd200, 32'h1234_5678));
    endtask

    // stale bounds after a base write, realigned by the next remove, and index wrap
    task automatic test_base_extremes();
        write_base(32'h8000_0000);
        send_item(make_cmd(FUNC_ADD, 32'h8000_0000, 32'h0000_0001));
        send_item(make_cmd(FUNC_ADD, 32'h8000_00FF, 32'hDEAD_BEEF));
        send_item(make_cmd(FUNC_REMOVE, 32'h8000_0000, 32'd0));
        write_base(32'h7FFF_FFFF);
        send_item(make_cmd(FUNC_ADD, 32'h7FFF_FFFF, 32'd77));
        send_item(make_cmd(FUNC_GET, 32'h8000_0000, 32'd0));
        send_item(make_cmd(FUNC_REMOVE, 32'h7FFF_FFFF, 32'd0));
        write_base(32'hFFFF_FFF0);
        send_item(make_cmd(FUNC_REMOVE, 32'h0000_00EF, 32'd0));
    endtask

    task automatic test_full_table();
        int order [DEPTH];
        int j;
        int tmp;
        logic [31:0] v;
        write_base(32'($urandom_range(0, 1200) - 600));
        for (int i = 0; i < DEPTH; i++) order[i] = i;
        for (int i = DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < DEPTH; i++) begin
            do v = $urandom; while (v == 32'd0);
            send_item(make_cmd(FUNC_ADD, base_reg + order[i], v));
        end
        for (int i = 0; i < 150; i++) begin
            send_item(make_cmd(pick_func(20), pick_index(0, DEPTH), pick_value()));
        end
    endtask

    task automatic test_random_phases();
        logic [31:0] new_base;
        int span;
        int lo_p;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: new_base = BASE_RESET;
                1: new_base = 32'h8000_0000;
                2: new_base = 32'h7FFF_FF80;
                3: new_base = 32'h7FFF_FFFF;
                5: new_base = 32'hFFFF_FFFF;
                6: new_base = 32'($urandom_range(0, 4000) - 2000);
                default: new_base = $urandom;
            endcase
            write_base(new_base);
            span = (ph % 2 == 1) ? 16 : DEPTH;
            lo_p = $urandom_range(0, DEPTH - span);
            if (ph == 2) lo_p = 0;
            no_gaps = (ph == 3 || ph == 6);
            for (int i = 0; i < 180; i++) begin
                send_item(make_cmd(pick_func((i < 60) ? 55 : 40), pick_index(lo_p, span),
                                   pick_value()));
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        fails = 0;
        no_gaps = 1'b0;
        for (int p = 0; p < DEPTH; p++) slot_mem[p] = 32'd0;
        occ_count = '0;
        low_bound = '0;
        high_bound = '0;
        base_reg = BASE_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_base_extremes();
        test_full_table();
        test_random_phases();
        wait_drained();
        if (fails == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
